// ===== rtl/oadf_pkg.sv =====
// Package for the obstacle-avoid drive controller: payload structs, register
// indexes, drive modes and turn request codes.
// No dependencies; imported by obstacle_avoid_drive_fsm_unit.
`timescale 1ns / 1ps
`default_nettype none

package oadf_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_FORWARD_LIMIT = 3'd0;
  localparam logic [2:0] REG_SIDE_LIMIT    = 3'd1;
  localparam logic [2:0] REG_ESCAPE_ANGLE  = 3'd2;
  localparam logic [2:0] REG_BIAS_PERIOD   = 3'd3;
  localparam logic [2:0] REG_TURN_PERIOD   = 3'd4;
  localparam logic [2:0] REG_FORWARD_SPEED = 3'd5;
  localparam logic [2:0] REG_TURN_RATE     = 3'd6;

  // Drive modes.
  localparam logic [1:0] MODE_CHOOSE  = 2'd0;
  localparam logic [1:0] MODE_FORWARD = 2'd1;
  localparam logic [1:0] MODE_RIGHT   = 2'd2;
  localparam logic [1:0] MODE_LEFT    = 2'd3;

  // Turn request codes.
  localparam logic [1:0] ASK_NONE  = 2'd0;
  localparam logic [1:0] ASK_RIGHT = 2'd1;
  localparam logic [1:0] ASK_LEFT  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_FORWARD_LIMIT = 16'd700;
  localparam logic [15:0] RST_SIDE_LIMIT    = 16'd600;
  localparam logic [15:0] RST_ESCAPE_ANGLE  = 16'd4289;
  localparam logic [15:0] RST_FORWARD_SPEED = 16'd300;
  localparam logic [14:0] RST_TURN_RATE     = 15'd1500;

  typedef struct packed {
    logic [15:0]        dist_front;
    logic [15:0]        dist_left;
    logic [15:0]        dist_right;
    logic signed [15:0] heading;
    logic               crash_seen;
    logic [1:0]         turn_ask;
    logic [15:0]        bias_draw;
    logic [15:0]        turn_draw;
    logic               side_draw;
  } in_item_t;

  typedef struct packed {
    logic               cmd_valid;
    logic [15:0]        linear_cmd;
    logic signed [15:0] angular_cmd;
    logic [1:0]         drive_state;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/obstacle_avoid_drive_fsm_unit.sv =====
// Obstacle-avoid drive controller top level: sequencer, shared remainder
// unit, drive state machine and configuration registers.
// Depends on oadf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// How to use this block:
// One transfer on the in_ channel is one control tick (ranges, heading, crash
// flag, turn request and three random draws). Every tick gives exactly one
// transfer on the out_ channel with the command and the drive mode after it.
// Both channels use valid/ready. Registers are written through cfg_we,
// cfg_addr and cfg_wdata while no tick is in flight.
// One shared 16-bit subtract-and-compare unit computes bias_draw mod
// bias_period and then turn_draw mod turn_period, one quotient bit per
// cycle, and the state machine is then applied in ST_EXEC. in_ready is
// high only between ticks, so a new tick is taken only once the last
// one has left the sequencer.
// The result sits in an output register; the next tick may be taken while
// it waits. If the receiver stalls, the finished tick holds in the
// sequencer and no state is updated until the output register is free.
// Synchronous active-low reset sets the registers to their defaults, the
// mode to choose, the bias to right, clears any pending request and the
// crash latch, and empties the output register.
module obstacle_avoid_drive_fsm_unit
  import oadf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire in_item_t    in_data,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      out_item_t   out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  // Configuration registers.
  logic [15:0] fwd_limit_r, side_limit_r, escape_r, bias_per_r, turn_per_r, fwd_speed_r;
  logic [14:0] turn_rate_r;

  // Sequencer and remainder unit.
  logic [1:0]  st_r, st_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        sel_r, sel_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] dvd_r, dvd_nxt;
  logic        bias_zero_r, bias_zero_nxt;
  logic        turn_zero_r, turn_zero_nxt;
  in_item_t    item_r, item_nxt;

  // Drive state.
  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] tsh_r, tsh_nxt;
  logic        prefer_r, prefer_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic        halted_r, halted_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        go;
  logic [15:0] divisor;
  logic [16:0] trial;
  logic [17:0] diff;
  logic [15:0] step_rem;
  out_item_t   res;
  logic [16:0] hd_diff;
  logic [16:0] hd_mag;
  logic [1:0]  pend_in;
  logic        halt_in;

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign go        = !out_valid_r || out_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_limit_r <= RST_FORWARD_LIMIT;
      side_limit_r <= RST_SIDE_LIMIT;
      escape_r <= RST_ESCAPE_ANGLE;
      bias_per_r <= '0;
      turn_per_r <= '0;
      fwd_speed_r <= RST_FORWARD_SPEED;
      turn_rate_r <= RST_TURN_RATE;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FORWARD_LIMIT: fwd_limit_r <= cfg_wdata;
        REG_SIDE_LIMIT:    side_limit_r <= cfg_wdata;
        REG_ESCAPE_ANGLE:  escape_r <= cfg_wdata;
        REG_BIAS_PERIOD:   bias_per_r <= cfg_wdata;
        REG_TURN_PERIOD:   turn_per_r <= cfg_wdata;
        REG_FORWARD_SPEED: fwd_speed_r <= cfg_wdata;
        REG_TURN_RATE:     turn_rate_r <= cfg_wdata[14:0];
        default: begin
        end
      endcase
    end
  end

  // Shared remainder unit: one restoring step per cycle.
  assign divisor  = sel_r ? turn_per_r : bias_per_r;
  assign trial    = {rem_r, dvd_r[15]};
  assign diff     = {1'b0, trial} - {2'b00, divisor};
  assign step_rem = diff[17] ? trial[15:0] : diff[15:0];

  // Drive state machine for one tick, using the two remainder flags.
  always_comb begin
    pend_in = (item_r.turn_ask == ASK_RIGHT || item_r.turn_ask == ASK_LEFT)
              ? item_r.turn_ask : pend_r;
    halt_in = halted_r | item_r.crash_seen;
    hd_diff = {tsh_r[15], tsh_r} - {item_r.heading[15], item_r.heading};
    hd_mag  = hd_diff[16] ? (17'd0 - hd_diff) : hd_diff;

    prefer_nxt = prefer_r;
    mode_nxt   = mode_r;
    tsh_nxt    = tsh_r;
    pend_nxt   = pend_in;
    halted_nxt = halt_in;
    res        = '0;

    if (!halt_in) begin
      if (pend_in == ASK_NONE && bias_per_r != '0 && bias_zero_r) begin
        prefer_nxt = !prefer_r;
      end
      case (mode_r)
        MODE_CHOOSE: begin
          if (item_r.dist_front > fwd_limit_r) begin
            if (prefer_nxt && item_r.dist_left < side_limit_r) begin
              tsh_nxt  = item_r.heading;
              mode_nxt = MODE_RIGHT;
            end else if (item_r.dist_right < side_limit_r) begin
              tsh_nxt  = item_r.heading;
              mode_nxt = MODE_LEFT;
            end else if (item_r.dist_left < side_limit_r) begin
              tsh_nxt  = item_r.heading;
              mode_nxt = MODE_RIGHT;
            end else begin
              mode_nxt = MODE_FORWARD;
            end
          end else if (item_r.dist_front < fwd_limit_r) begin
            tsh_nxt  = item_r.heading;
            mode_nxt = prefer_nxt ? MODE_RIGHT : MODE_LEFT;
          end
        end
        MODE_FORWARD: begin
          if (turn_per_r != '0 && turn_zero_r) begin
            tsh_nxt  = item_r.heading;
            mode_nxt = item_r.side_draw ? MODE_LEFT : MODE_RIGHT;
          end else if (pend_in != ASK_NONE) begin
            tsh_nxt  = item_r.heading;
            mode_nxt = (pend_in == ASK_RIGHT) ? MODE_RIGHT : MODE_LEFT;
            pend_nxt = ASK_NONE;
          end else begin
            res.cmd_valid  = 1'b1;
            res.linear_cmd = fwd_speed_r;
            mode_nxt       = MODE_CHOOSE;
          end
        end
        default: begin
          // Either turn: run until the heading has moved far enough.
          pend_nxt = ASK_NONE;
          if (hd_mag >= {1'b0, escape_r}) begin
            mode_nxt = MODE_CHOOSE;
          end else begin
            res.cmd_valid   = 1'b1;
            res.angular_cmd = (mode_r == MODE_RIGHT) ? (16'd0 - {1'b0, turn_rate_r})
                                                     : {1'b0, turn_rate_r};
          end
        end
      endcase
    end
    res.drive_state = mode_nxt;
  end

  // Sequencer.
  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    bias_zero_nxt = bias_zero_r;
    turn_zero_nxt = turn_zero_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          dvd_nxt  = in_data.bias_draw;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          sel_nxt  = 1'b0;
          st_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = step_rem;
        dvd_nxt = {dvd_r[14:0], 1'b0};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          if (!sel_r) begin
            bias_zero_nxt = (step_rem == '0);
            sel_nxt       = 1'b1;
            rem_nxt       = '0;
            dvd_nxt       = item_r.turn_draw;
          end else begin
            turn_zero_nxt = (step_rem == '0);
            st_nxt        = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control and drive-state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_CHOOSE;
      tsh_r       <= '0;
      prefer_r    <= 1'b1;
      pend_r      <= ASK_NONE;
      halted_r    <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (st_r == ST_EXEC && go) begin
        mode_r   <= mode_nxt;
        tsh_r    <= tsh_nxt;
        prefer_r <= prefer_nxt;
        pend_r   <= pend_nxt;
        halted_r <= halted_nxt;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    sel_r       <= sel_nxt;
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
    bias_zero_r <= bias_zero_nxt;
    turn_zero_r <= turn_zero_nxt;
    item_r      <= item_nxt;
    out_data_r  <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // A taken tick starts the bias remainder from its first step.
  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (st_r == ST_DIV && cnt_r == 4'd0 && !sel_r))
    else $error("division did not start after input transfer");

  // The partial remainder stays below a nonzero divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV && divisor != '0) |-> (rem_r < divisor))
    else $error("partial remainder out of range");

  // A halted block never issues a command.
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EXEC && go && halted_r) |=> (out_valid && !out_data.cmd_valid))
    else $error("command issued while halted");

  // The output register is loaded only when it is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EXEC && out_valid_r && !out_ready) |=> (st_r == ST_EXEC))
    else $error("result left the sequencer while the output was stalled");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_obstacle_avoid_drive_fsm_unit.sv =====
// Self-checking testbench for obstacle_avoid_drive_fsm_unit: directed ticks, then random
// control ticks over several register settings, each result checked against a fixed expectation or a local model.
// Depends on oadf_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb_obstacle_avoid_drive_fsm_unit;
  import oadf_pkg::*;

  localparam int HEAD_MAX = 25736;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 40;
  localparam logic [15:0] ESCAPE_MAX = 16'd51472;
  // Request code three is reserved and must leave the queued request alone.
  localparam logic [1:0] ASK_RESERVED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  obstacle_avoid_drive_fsm_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the register file and of the drive state.
  logic [15:0]        reg_copy [0:6];
  logic [1:0]         st_mode = MODE_CHOOSE;
  logic signed [15:0] st_turn_from = '0;
  logic               st_lean_right = 1'b1;
  logic [1:0]         st_queued_ask = ASK_NONE;
  logic               st_stopped = 1'b0;

  out_item_t due_cmds [$];
  out_item_t head_cmd;
  int        miss_count = 0;
  int        cycles = 0;
  int        walk_heading = 0;
  int        stall_left = 0;
  bit        steady = 1'b0;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  addr;
    logic [15:0] val;
    in_item_t    tick;
    bit          typed;
    out_item_t   want;
  } plan_row_t;

  plan_row_t plan [$];

  // Advance the drive state by one tick and return the command it gives.
  function automatic out_item_t drive_cmd_of(in_item_t t);
    out_item_t          r;
    int                 diff;
    logic signed [15:0] rate;
    r = '0;
    rate = $signed({1'b0, reg_copy[REG_TURN_RATE][14:0]});
    if (t.turn_ask == ASK_RIGHT || t.turn_ask == ASK_LEFT) st_queued_ask = t.turn_ask;
    if (t.crash_seen) st_stopped = 1'b1;
    if (!st_stopped) begin
      if (st_queued_ask == ASK_NONE && reg_copy[REG_BIAS_PERIOD] != 16'd0 &&
          t.bias_draw % reg_copy[REG_BIAS_PERIOD] == 16'd0)
        st_lean_right = !st_lean_right;
      case (st_mode)
        MODE_CHOOSE: begin
          if (t.dist_front > reg_copy[REG_FORWARD_LIMIT]) begin
            if (st_lean_right && t.dist_left < reg_copy[REG_SIDE_LIMIT]) begin
              st_turn_from = t.heading;
              st_mode = MODE_RIGHT;
            end else if (t.dist_right < reg_copy[REG_SIDE_LIMIT]) begin
              st_turn_from = t.heading;
              st_mode = MODE_LEFT;
            end else if (t.dist_left < reg_copy[REG_SIDE_LIMIT]) begin
              st_turn_from = t.heading;
              st_mode = MODE_RIGHT;
            end else begin
              st_mode = MODE_FORWARD;
            end
          end else if (t.dist_front < reg_copy[REG_FORWARD_LIMIT]) begin
            st_turn_from = t.heading;
            st_mode = st_lean_right ? MODE_RIGHT : MODE_LEFT;
          end
        end
        MODE_FORWARD: begin
          // A random turn beats a queued request, which then stays queued.
          if (reg_copy[REG_TURN_PERIOD] != 16'd0 &&
              t.turn_draw % reg_copy[REG_TURN_PERIOD] == 16'd0) begin
            st_turn_from = t.heading;
            st_mode = t.side_draw ? MODE_LEFT : MODE_RIGHT;
          end else if (st_queued_ask != ASK_NONE) begin
            st_turn_from = t.heading;
            st_mode = (st_queued_ask == ASK_RIGHT) ? MODE_RIGHT : MODE_LEFT;
            st_queued_ask = ASK_NONE;
          end else begin
            r.cmd_valid = 1'b1;
            r.linear_cmd = reg_copy[REG_FORWARD_SPEED];
            st_mode = MODE_CHOOSE;
          end
        end
        default: begin
          // Turning: the heading difference is taken without wrap-around.
          diff = int'(st_turn_from) - int'($signed(t.heading));
          if (diff < 0) diff = -diff;
          st_queued_ask = ASK_NONE;
          if (diff >= int'(reg_copy[REG_ESCAPE_ANGLE])) begin
            st_mode = MODE_CHOOSE;
          end else begin
            r.cmd_valid = 1'b1;
            r.angular_cmd = (st_mode == MODE_RIGHT) ? -rate : rate;
          end
        end
      endcase
    end
    r.drive_state = st_mode;
    return r;
  endfunction

  function automatic in_item_t mk(input logic [15:0] f, input logic [15:0] l,
                                  input logic [15:0] r, input int hd, input logic [1:0] ask,
                                  input logic [15:0] bd, input logic [15:0] td,
                                  input logic sd);
    in_item_t t;
    t = '0;
    t.dist_front = f;
    t.dist_left = l;
    t.dist_right = r;
    t.heading = 16'(hd);
    t.turn_ask = ask;
    t.bias_draw = bd;
    t.turn_draw = td;
    t.side_draw = sd;
    return t;
  endfunction

  function automatic void add_tick(in_item_t t);
    plan_row_t row;
    row = '{default: '0};
    row.tick = t;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_fixed(in_item_t t, out_item_t w);
    plan_row_t row;
    row = '{default: '0};
    row.tick = t;
    row.typed = 1'b1;
    row.want = w;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_cfg(logic [2:0] a, logic [15:0] v);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.addr = a;
    row.val = v;
    plan.insert(plan.size(), row);
  endfunction

  // Distances cluster around the active limit so both sides of each compare are hit.
  function automatic logic [15:0] near_limit(logic [15:0] lim);
    case ($urandom_range(7))
      0: return lim;
      1: return lim - 16'd1;
      2: return lim + 16'd1;
      3: return 16'($urandom_range(int'(lim)));
      4: return 16'($urandom_range(65535, int'(lim)));
      5: return 16'hFFFF;
      6: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // A quarter of the draws are multiples of the period so the random tests fire.
  function automatic logic [15:0] draw_for(logic [15:0] p);
    if (p != 16'd0 && $urandom_range(3) == 0)
      return 16'(int'(p) * int'($urandom_range(65535 / int'(p))));
    return 16'($urandom);
  endfunction

  // Random tick; while turning, the heading sweeps away from where the turn began.
  function automatic in_item_t roam_tick();
    in_item_t t;
    int       step;
    t = '0;
    if (st_mode == MODE_RIGHT || st_mode == MODE_LEFT) begin
      step = int'(reg_copy[REG_ESCAPE_ANGLE]) / int'($urandom_range(5, 1)) +
             int'($urandom_range(200));
      if (walk_heading < int'(st_turn_from)) step = -step;
    end else begin
      step = int'($urandom_range(2400)) - 1200;
    end
    case ($urandom_range(19))
      0: walk_heading = HEAD_MAX;
      1: walk_heading = -HEAD_MAX;
      2: walk_heading = int'($urandom_range(2 * HEAD_MAX)) - HEAD_MAX;
      default: walk_heading = walk_heading + step;
    endcase
    if (walk_heading > HEAD_MAX) walk_heading = HEAD_MAX;
    if (walk_heading < -HEAD_MAX) walk_heading = -HEAD_MAX;
    t.dist_front = near_limit(reg_copy[REG_FORWARD_LIMIT]);
    t.dist_left = near_limit(reg_copy[REG_SIDE_LIMIT]);
    t.dist_right = near_limit(reg_copy[REG_SIDE_LIMIT]);
    t.heading = 16'(walk_heading);
    t.turn_ask = ($urandom_range(9) < 7) ? ASK_NONE : 2'($urandom_range(3));
    t.bias_draw = draw_for(reg_copy[REG_BIAS_PERIOD]);
    t.turn_draw = draw_for(reg_copy[REG_TURN_PERIOD]);
    t.side_draw = 1'($urandom_range(1));
    return t;
  endfunction

  // Register write, one cycle long, issued from a falling edge.
  task automatic write_reg(logic [2:0] a, logic [15:0] v);
    cfg_we = 1'b1;
    cfg_addr = a;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    reg_copy[a] = (a == REG_TURN_RATE) ? {1'b0, v[14:0]} : v;
  endtask

  task automatic write_all(logic [15:0] fl, logic [15:0] sl, logic [15:0] ea,
                           logic [15:0] bp, logic [15:0] tp, logic [15:0] fs,
                           logic [15:0] tr);
    write_reg(REG_FORWARD_LIMIT, fl);
    write_reg(REG_SIDE_LIMIT, sl);
    write_reg(REG_ESCAPE_ANGLE, ea);
    write_reg(REG_BIAS_PERIOD, bp);
    write_reg(REG_TURN_PERIOD, tp);
    write_reg(REG_FORWARD_SPEED, fs);
    write_reg(REG_TURN_RATE, tr);
  endtask

  // Every tick gives one result, so an empty queue means the block is idle.
  task automatic settle();
    while (due_cmds.size() != 0) @(negedge clk);
  endtask

  // One input transfer; the expected command is queued at the accepting edge.
  task automatic send_tick(in_item_t t, bit typed, out_item_t want);
    out_item_t guess;
    if (!steady && $urandom_range(99) < 20) begin
      in_valid = 1'b0;
      repeat ($urandom_range(40, 1)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = drive_cmd_of(t);
    due_cmds.insert(due_cmds.size(), typed ? want : guess);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic note_miss(string what, out_item_t want, out_item_t got);
    miss_count++;
    if (miss_count <= 10)
      $display("MISMATCH %s: exp v=%0d lin=%0d ang=%0d st=%0d  got v=%0d lin=%0d ang=%0d st=%0d",
               what, want.cmd_valid, want.linear_cmd, want.angular_cmd, want.drive_state,
               got.cmd_valid, got.linear_cmd, got.angular_cmd, got.drive_state);
  endtask

  // Receiver: mostly ready, short stalls and now and then a long one.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if (steady) begin
      out_ready = 1'b1;
    end else if ($urandom_range(999) < 1) begin
      stall_left = $urandom_range(80, 1);
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= 6);
    end
  end

  // Result checker: each output transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_cmds.size() == 0) begin
        note_miss("unexpected result", '0, out_data);
      end else begin
        head_cmd = due_cmds.pop_front();
        if (head_cmd.cmd_valid !== out_data.cmd_valid ||
            head_cmd.linear_cmd !== out_data.linear_cmd ||
            head_cmd.angular_cmd !== out_data.angular_cmd ||
            head_cmd.drive_state !== out_data.drive_state)
          note_miss("field", head_cmd, out_data);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    in_item_t t;
    reg_copy[REG_FORWARD_LIMIT] = RST_FORWARD_LIMIT;
    reg_copy[REG_SIDE_LIMIT] = RST_SIDE_LIMIT;
    reg_copy[REG_ESCAPE_ANGLE] = RST_ESCAPE_ANGLE;
    reg_copy[REG_BIAS_PERIOD] = 16'd0;
    reg_copy[REG_TURN_PERIOD] = 16'd0;
    reg_copy[REG_FORWARD_SPEED] = RST_FORWARD_SPEED;
    reg_copy[REG_TURN_RATE] = {1'b0, RST_TURN_RATE};

    // Directed ticks from reset defaults: limit 700, side 600, escape 4289.
    // Front equal to the limit makes no decision.
    add_fixed(mk(16'd700, 16'd1000, 16'd1000, 0, ASK_NONE, 16'd0, 16'd0, 1'b0),
              '{1'b0, 16'd0, 16'sd0, MODE_CHOOSE});
    add_fixed(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, ASK_NONE, 16'hFFFF, 16'hFFFF, 1'b1),
              '{1'b0, 16'd0, 16'sd0, MODE_FORWARD});
    add_fixed(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, ASK_NONE, 16'd0, 16'd0, 1'b0),
              '{1'b1, 16'd300, 16'sd0, MODE_CHOOSE});
    add_fixed(mk(16'd0, 16'd0, 16'd0, 100, ASK_NONE, 16'd0, 16'd0, 1'b0),
              '{1'b0, 16'd0, 16'sd0, MODE_RIGHT});
    // One short of the escape angle, then exactly on it.
    add_fixed(mk(16'd0, 16'd0, 16'd0, -4188, ASK_NONE, 16'd0, 16'd0, 1'b0),
              '{1'b1, 16'd0, -16'sd1500, MODE_RIGHT});
    add_fixed(mk(16'd0, 16'd0, 16'd0, -4189, ASK_NONE, 16'd0, 16'd0, 1'b0),
              '{1'b0, 16'd0, 16'sd0, MODE_CHOOSE});
    add_tick(mk(16'hFFFF, 16'd0, 16'hFFFF, -HEAD_MAX, ASK_RESERVED, 16'd0, 16'd0, 1'b0));
    // Request arriving during a turn is dropped; full heading swing ends the turn.
    add_tick(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, HEAD_MAX, ASK_LEFT, 16'd0, 16'd0, 1'b0));
    add_tick(mk(16'hFFFF, 16'hFFFF, 16'd0, 0, ASK_NONE, 16'd0, 16'd0, 1'b0));
    add_fixed(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, ASK_NONE, 16'd0, 16'd0, 1'b0),
              '{1'b1, 16'd0, 16'sd1500, MODE_LEFT});
    add_tick(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 5000, ASK_NONE, 16'd0, 16'd0, 1'b0));
    add_tick(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, ASK_RIGHT, 16'd0, 16'd0, 1'b0));
    add_tick(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, ASK_NONE, 16'd0, 16'd0, 1'b0));
    add_tick(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, -HEAD_MAX, ASK_NONE, 16'd0, 16'd0, 1'b0));
    // Random tests enabled: bias held while a request waits, random turn wins.
    add_cfg(REG_BIAS_PERIOD, 16'd2);
    add_cfg(REG_TURN_PERIOD, 16'd3);
    add_tick(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, ASK_LEFT, 16'd0, 16'd1, 1'b0));
    add_tick(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 1000, ASK_NONE, 16'd0, 16'd3, 1'b1));
    add_tick(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 1000, ASK_NONE, 16'd1, 16'd1, 1'b0));
    add_tick(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, -HEAD_MAX, ASK_NONE, 16'd1, 16'd1, 1'b0));
    add_tick(mk(16'd0, 16'hFFFF, 16'hFFFF, 0, ASK_NONE, 16'd4, 16'd1, 1'b0));
    add_tick(mk(16'd0, 16'hFFFF, 16'hFFFF, HEAD_MAX, ASK_NONE, 16'd1, 16'd1, 1'b0));
    add_cfg(REG_FORWARD_LIMIT, 16'd0);
    add_cfg(REG_ESCAPE_ANGLE, ESCAPE_MAX);
    add_fixed(mk(16'd0, 16'hFFFF, 16'hFFFF, 0, ASK_NONE, 16'd1, 16'd1, 1'b0),
              '{1'b0, 16'd0, 16'sd0, MODE_CHOOSE});
    add_tick(mk(16'd1, 16'd0, 16'd0, HEAD_MAX, ASK_RESERVED, 16'd1, 16'd1, 1'b0));
    add_tick(mk(16'd1, 16'd0, 16'd0, -HEAD_MAX, ASK_NONE, 16'd1, 16'd1, 1'b0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].addr, plan[i].val);
      end else begin
        send_tick(plan[i].tick, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: write_all(RST_FORWARD_LIMIT, RST_SIDE_LIMIT, RST_ESCAPE_ANGLE, 16'd0, 16'd0,
                     RST_FORWARD_SPEED, {1'b0, RST_TURN_RATE});
        1: write_all(16'd1000, 16'd800, 16'd3000, 16'd3, 16'd5, 16'd1234, 16'h8123);
        2: write_all(16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0);
        3: write_all(16'hFFFF, 16'hFFFF, ESCAPE_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        default: write_all(16'($urandom_range(3000, 300)), 16'($urandom_range(2500, 200)),
                           16'($urandom_range(9000, 500)), 16'($urandom_range(6)),
                           16'($urandom_range(9)), 16'($urandom), 16'($urandom));
      endcase
      // Phase two runs with neither side idling.
      steady = (ph == 2);
      repeat (290) send_tick(roam_tick(), 1'b0, '0);
    end
    steady = 1'b0;

    // A crash stops the block for good, so it comes last.
    t = roam_tick();
    t.crash_seen = 1'b1;
    send_tick(t, 1'b0, '0);
    repeat (8) begin
      t = roam_tick();
      t.crash_seen = 1'($urandom_range(1));
      send_tick(t, 1'b0, '0);
    end

    while (due_cmds.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (miss_count == 0 && due_cmds.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
